[rtl/core/ple_pkg.sv]
`default_nettype none

package ple_pkg;

	// List geometry
	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	// Field widths on the stream ports
	localparam int FUNC_W   = 3;
	localparam int POS_W    = 8;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int FOUND_W  = 5;
	localparam int COUNT_W  = 5;
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 48;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_INSERT = 3'd0,
		FUNC_DELETE = 3'd1,
		FUNC_UPDATE = 3'd2,
		FUNC_SEARCH = 3'd3,
		FUNC_CLEAR  = 3'd4
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_BADPOS   = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_RUN  = 2'd1,
		S_DONE = 2'd2
	} state_t;

	// Write port of the entry store
	typedef struct packed {
		logic                  en;
		logic [IDX_W-1:0]      addr;
		logic [DATA_WIDTH-1:0] data;
	} mem_wr_t;

	// Read port of the entry store
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} mem_rd_t;

	// Sign-extend or cut the 32-bit input value to the stored width
	function automatic logic [DATA_WIDTH-1:0] narrow_value(input logic signed [VALUE_W-1:0] v);
		return DATA_WIDTH'(v);
	endfunction

	// Sign-extend or cut a stored entry to the 32-bit output field
	function automatic logic [VALUE_W-1:0] widen_value(input logic [DATA_WIDTH-1:0] v);
		logic signed [DATA_WIDTH-1:0] sv;
		sv = signed'(v);
		return VALUE_W'(sv);
	endfunction

endpackage

`default_nettype wire

[rtl/core/ple_mem.sv]
`default_nettype none

// Entry store: one write port, one read port, registered read data
module ple_mem (
	input  wire                                 clk,
	input  wire ple_pkg::mem_wr_t               wr,
	input  wire ple_pkg::mem_rd_t               rd,
	output logic [ple_pkg::DATA_WIDTH-1:0]      rd_data
);

	logic [ple_pkg::DATA_WIDTH-1:0] mem [ple_pkg::CAPACITY];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/positional_list_engine_unit.sv]
`default_nettype none

// Ordered list of CAPACITY values edited by 1-based position.
// Command stream (s_*): one transfer per command: insert, delete, update,
// search or clear. Result stream (m_*): exactly one transfer per command,
// carrying status, removed value, match position and entry count.
// Commands are worked one at a time out of a single-port-write,
// single-port-read entry RAM with registered read data:
//  - update, clear, append-insert and rejected commands are decided at
//    the command transfer, without a walk through the RAM.
//  - insert at position p: one read/write pair per shifted entry, from
//    the last entry back to p, then the new value is written.
//  - delete at position p: the entries after p move one place forward;
//    search walks from the first entry and stops after the first match.
// The walk through the RAM goes at one entry per cycle.
// The result sits in an output register; the engine takes the next command
// while it waits and only holds its own finished result until the output
// register frees. A stalled m_tready therefore stalls at most one command.
// Reset empties the list (count zero); the RAM itself is not cleared.
module positional_list_engine_unit (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// [2:0] func, [10:3] position, [42:11] value, [47:43] zero
	input  wire  [ple_pkg::S_TDATA_W-1:0]     s_tdata,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// [1:0] status, [33:2] data_out, [38:34] found_at, [43:39] count, [47:44] zero
	output logic [ple_pkg::M_TDATA_W-1:0]     m_tdata
);

	localparam int IDX_W = ple_pkg::IDX_W;
	localparam int CNT_W = ple_pkg::CNT_W;
	localparam int DW    = ple_pkg::DATA_WIDTH;

	// Control state
	ple_pkg::state_t   state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              rd_go_q;
	logic              rd_v_s1;
	logic              m_tvalid_q;

	// Command payload
	ple_pkg::func_t    op_q;
	logic [IDX_W-1:0]  k_q;
	logic [DW-1:0]     val_q;
	logic [IDX_W-1:0]  ptr_q;
	logic [IDX_W-1:0]  addr_s1;
	ple_pkg::status_t  status_q;
	logic [ple_pkg::VALUE_W-1:0] data_q;
	logic [ple_pkg::FOUND_W-1:0] found_q;

	// Output register fields
	ple_pkg::status_t             out_status_q;
	logic [ple_pkg::VALUE_W-1:0]  out_data_q;
	logic [ple_pkg::FOUND_W-1:0]  out_found_q;
	logic [ple_pkg::COUNT_W-1:0]  out_count_q;

	// RAM ports
	ple_pkg::mem_wr_t  wr;
	ple_pkg::mem_rd_t  rd;
	logic [DW-1:0]     rd_data;

	// Input fields
	ple_pkg::func_t              in_func;
	logic [ple_pkg::POS_W-1:0]   in_pos;
	logic [DW-1:0]               in_val;
	logic [IDX_W-1:0]            in_k;
	logic                        pos_zero;
	logic                        pos_gt_cnt;
	logic                        pos_gt_cnt1;
	logic                        accept;

	// Decision at command transfer
	logic              acc_run;
	ple_pkg::status_t  acc_status;

	// Walk control
	logic              drained;
	logic              match;
	logic [IDX_W-1:0]  ptr_end;
	logic              load_out;

	assign in_func = ple_pkg::func_t'(s_tdata[2:0]);
	assign in_pos  = s_tdata[10:3];
	assign in_val  = ple_pkg::narrow_value(signed'(s_tdata[42:11]));
	assign in_k    = IDX_W'(in_pos - ple_pkg::POS_W'(1));

	assign pos_zero    = (in_pos == '0);
	assign pos_gt_cnt  = ({1'b0, in_pos} > 9'(cnt_q));
	assign pos_gt_cnt1 = ({1'b0, in_pos} > (9'(cnt_q) + 9'd1));

	assign s_tready = (state_q == ple_pkg::S_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign drained  = !rd_go_q && !rd_v_s1;
	assign match    = rd_v_s1 && (op_q == ple_pkg::FUNC_SEARCH) && (rd_data == val_q);
	assign ptr_end  = (op_q == ple_pkg::FUNC_INSERT) ? k_q : IDX_W'(cnt_q - CNT_W'(1));

	// Next state, RAM accesses and count update
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		acc_run    = 1'b0;
		acc_status = ple_pkg::ST_OK;
		load_out   = 1'b0;
		wr         = '0;
		rd.en      = 1'b0;
		rd.addr    = ptr_q;
		unique case (state_q)
			ple_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_d = ple_pkg::S_DONE;
					unique case (in_func)
						ple_pkg::FUNC_INSERT: begin
							if (pos_zero || pos_gt_cnt1) begin
								acc_status = ple_pkg::ST_BADPOS;
							end else if (cnt_q == CNT_W'(ple_pkg::CAPACITY)) begin
								acc_status = ple_pkg::ST_FULL;
							end else if (pos_gt_cnt) begin
								// append: no entries to move
								wr.en   = 1'b1;
								wr.addr = in_k;
								wr.data = in_val;
								cnt_d   = cnt_q + CNT_W'(1);
							end else begin
								acc_run = 1'b1;
								state_d = ple_pkg::S_RUN;
							end
						end
						ple_pkg::FUNC_DELETE: begin
							if (pos_zero || pos_gt_cnt) begin
								acc_status = ple_pkg::ST_BADPOS;
							end else begin
								acc_run = 1'b1;
								state_d = ple_pkg::S_RUN;
							end
						end
						ple_pkg::FUNC_UPDATE: begin
							if (pos_zero || pos_gt_cnt) begin
								acc_status = ple_pkg::ST_BADPOS;
							end else begin
								wr.en   = 1'b1;
								wr.addr = in_k;
								wr.data = in_val;
							end
						end
						ple_pkg::FUNC_SEARCH: begin
							acc_status = ple_pkg::ST_NOTFOUND;
							if (cnt_q != '0) begin
								acc_run = 1'b1;
								state_d = ple_pkg::S_RUN;
							end
						end
						ple_pkg::FUNC_CLEAR: begin
							cnt_d = '0;
						end
						default: begin
							acc_status = ple_pkg::ST_OK;
						end
					endcase
				end
			end
			ple_pkg::S_RUN: begin
				rd.en = rd_go_q;
				// move the entry read last cycle one place back or forward
				if (rd_v_s1 && op_q == ple_pkg::FUNC_INSERT) begin
					wr.en   = 1'b1;
					wr.addr = addr_s1 + IDX_W'(1);
					wr.data = rd_data;
				end else if (rd_v_s1 && op_q == ple_pkg::FUNC_DELETE && addr_s1 != k_q) begin
					wr.en   = 1'b1;
					wr.addr = addr_s1 - IDX_W'(1);
					wr.data = rd_data;
				end
				if (drained) begin
					state_d = ple_pkg::S_DONE;
					if (op_q == ple_pkg::FUNC_INSERT) begin
						wr.en   = 1'b1;
						wr.addr = k_q;
						wr.data = val_q;
						cnt_d   = cnt_q + CNT_W'(1);
					end else if (op_q == ple_pkg::FUNC_DELETE) begin
						cnt_d = cnt_q - CNT_W'(1);
					end
				end
			end
			ple_pkg::S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ple_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ple_pkg::S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ple_pkg::S_IDLE;
			cnt_q      <= '0;
			rd_go_q    <= 1'b0;
			rd_v_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			rd_v_s1 <= rd.en && !match;
			if (accept) begin
				rd_go_q <= acc_run;
			end else if (match) begin
				rd_go_q <= 1'b0;
			end else if (rd_go_q && ptr_q == ptr_end) begin
				rd_go_q <= 1'b0;
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Command payload and walk pointer
	always_ff @(posedge clk) begin
		addr_s1 <= ptr_q;
		if (accept) begin
			op_q     <= in_func;
			k_q      <= in_k;
			val_q    <= in_val;
			status_q <= acc_status;
			data_q   <= '0;
			found_q  <= '0;
			if (in_func == ple_pkg::FUNC_INSERT) begin
				ptr_q <= IDX_W'(cnt_q - CNT_W'(1));
			end else if (in_func == ple_pkg::FUNC_DELETE) begin
				ptr_q <= in_k;
			end else begin
				ptr_q <= '0;
			end
		end else begin
			if (rd_go_q && ptr_q != ptr_end) begin
				if (op_q == ple_pkg::FUNC_INSERT) begin
					ptr_q <= ptr_q - IDX_W'(1);
				end else begin
					ptr_q <= ptr_q + IDX_W'(1);
				end
			end
			if (rd_v_s1 && op_q == ple_pkg::FUNC_DELETE && addr_s1 == k_q) begin
				data_q <= ple_pkg::widen_value(rd_data);
			end
			if (match) begin
				status_q <= ple_pkg::ST_OK;
				found_q  <= ple_pkg::FOUND_W'({1'b0, addr_s1} + (IDX_W + 1)'(1));
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= status_q;
			out_data_q   <= data_q;
			out_found_q  <= found_q;
			out_count_q  <= ple_pkg::COUNT_W'(cnt_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0, out_count_q, out_found_q, out_data_q, out_status_q};

	ple_mem u_mem (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

endmodule

`default_nettype wire
